// ===== rtl/core/cde_pkg.sv =====
// Shared types and codes for the circular deque engine.
package cde_pkg;

  typedef enum logic [1:0] {
    REQ_INS_REAR  = 2'd0,
    REQ_INS_FRONT = 2'd1,
    REQ_DEL_FRONT = 2'd2,
    REQ_DEL_REAR  = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_DONE   = 2'd0,
    ST_FULL   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_DENIED = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    MODE_IN_RESTR  = 2'd0,
    MODE_OUT_RESTR = 2'd1,
    MODE_FREE      = 2'd2,
    MODE_FREE_ALT  = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_PUSH_REAR,
    OP_PUSH_FRONT,
    OP_POP_FRONT,
    OP_POP_REAR
  } op_t;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } fsm_t;

  localparam logic [2:0] REG_MODE_ADDR = 3'd0;
  localparam logic [1:0] MODE_RESET    = 2'd2;

  typedef struct packed {
    logic    exec;
    op_t     op;
    status_t status;
    logic    load_out;
  } cmd_t;

  typedef struct packed {
    logic  is_empty;
    logic  is_full;
    mode_t mode;
    logic  out_valid;
  } dp_stat_t;

endpackage

// ===== rtl/core/cde_ctrl.sv =====
// Controller state machine: accepts a request, decides the operation, loads the result.
module cde_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [1:0]        req_bits,
  input  logic              m_tready,
  input  cde_pkg::dp_stat_t stat,
  output cde_pkg::cmd_t     cmd
);

  cde_pkg::fsm_t state;
  cde_pkg::fsm_t state_next;
  cde_pkg::req_t req;
  logic          denied;
  logic          out_free;

  assign req      = cde_pkg::req_t'(req_bits);
  assign out_free = !stat.out_valid || m_tready;
  assign denied   = (stat.mode == cde_pkg::MODE_IN_RESTR  && req == cde_pkg::REQ_INS_FRONT) ||
                    (stat.mode == cde_pkg::MODE_OUT_RESTR && req == cde_pkg::REQ_DEL_REAR);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cde_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      cde_pkg::S_IDLE: begin
        if (s_tvalid) begin
          state_next = cde_pkg::S_EXEC;
        end
      end
      cde_pkg::S_EXEC: begin
        if (out_free) begin
          state_next = cde_pkg::S_IDLE;
        end
      end
      default: state_next = cde_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    s_tready     = 1'b0;
    cmd.exec     = 1'b0;
    cmd.op       = cde_pkg::OP_NOP;
    cmd.status   = cde_pkg::ST_DONE;
    cmd.load_out = 1'b0;
    unique case (state)
      cde_pkg::S_IDLE: begin
        s_tready = 1'b1;
        cmd.exec = s_tvalid;
        if (denied) begin
          cmd.status = cde_pkg::ST_DENIED;
        end else begin
          unique case (req)
            cde_pkg::REQ_INS_REAR,
            cde_pkg::REQ_INS_FRONT: begin
              if (stat.is_full) begin
                cmd.status = cde_pkg::ST_FULL;
              end else begin
                cmd.op = (req == cde_pkg::REQ_INS_REAR) ? cde_pkg::OP_PUSH_REAR
                                                        : cde_pkg::OP_PUSH_FRONT;
              end
            end
            cde_pkg::REQ_DEL_FRONT,
            cde_pkg::REQ_DEL_REAR: begin
              if (stat.is_empty) begin
                cmd.status = cde_pkg::ST_EMPTY;
              end else begin
                cmd.op = (req == cde_pkg::REQ_DEL_FRONT) ? cde_pkg::OP_POP_FRONT
                                                         : cde_pkg::OP_POP_REAR;
              end
            end
            default: cmd.op = cde_pkg::OP_NOP;
          endcase
        end
        // drop the operation unless an item is actually accepted
        if (!s_tvalid) begin
          cmd.op = cde_pkg::OP_NOP;
        end
      end
      cde_pkg::S_EXEC: begin
        cmd.load_out = out_free;
      end
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

endmodule

// ===== rtl/core/cde_datapath.sv =====
// Datapath: slot memory, ring pointers, mode register and output register.
module cde_datapath #(
  parameter int DEPTH = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  cde_pkg::cmd_t     cmd,
  output cde_pkg::dp_stat_t stat,
  input  logic [31:0]       value,
  input  logic              m_tready,
  output logic              m_tvalid,
  output logic [39:0]       m_tdata,
  output logic [1:0]        m_tuser,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
  localparam logic REG_MODE_SEL = cde_pkg::REG_MODE_ADDR[2];

  function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] i);
    return (i == LAST) ? '0 : i + AW'(1);
  endfunction

  function automatic logic [AW-1:0] ring_prev(input logic [AW-1:0] i);
    return (i == '0) ? LAST : i - AW'(1);
  endfunction

  logic [31:0]     mem [DEPTH];
  logic [AW-1:0]   front;
  logic [AW-1:0]   rear;
  logic            empty;
  cde_pkg::mode_t  mode;
  logic [AW-1:0]   front_next;
  logic [AW-1:0]   rear_next;
  logic            empty_next;
  logic            full;
  logic            full_next;
  logic            wr_en;
  logic            rd_en;
  logic [AW-1:0]   wr_addr;
  logic [AW-1:0]   rd_addr;
  logic [31:0]     rd_data;
  cde_pkg::status_t pend_status;
  logic            pend_pop;
  logic            pend_empty;
  logic            pend_full;
  logic            out_valid;
  logic            cfg_wr;
  logic [31:0]     out_data;
  cde_pkg::status_t out_status;
  logic            out_empty;
  logic            out_full;

  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_MODE_SEL);

  assign full      = !empty && (ring_next(rear) == front);
  assign full_next = !empty_next && (ring_next(rear_next) == front_next);

  always_comb begin
    front_next = front;
    rear_next  = rear;
    empty_next = empty;
    wr_en      = 1'b0;
    rd_en      = 1'b0;
    wr_addr    = front;
    rd_addr    = front;
    case (cmd.op)
      cde_pkg::OP_PUSH_REAR,
      cde_pkg::OP_PUSH_FRONT: begin
        wr_en = 1'b1;
        if (empty) begin
          front_next = '0;
          rear_next  = '0;
          empty_next = 1'b0;
          wr_addr    = '0;
        end else if (cmd.op == cde_pkg::OP_PUSH_REAR) begin
          rear_next = ring_next(rear);
          wr_addr   = ring_next(rear);
        end else begin
          front_next = ring_prev(front);
          wr_addr    = ring_prev(front);
        end
      end
      cde_pkg::OP_POP_FRONT,
      cde_pkg::OP_POP_REAR: begin
        rd_en   = 1'b1;
        rd_addr = (cmd.op == cde_pkg::OP_POP_FRONT) ? front : rear;
        if (front == rear) begin
          front_next = '0;
          rear_next  = '0;
          empty_next = 1'b1;
        end else if (cmd.op == cde_pkg::OP_POP_FRONT) begin
          front_next = ring_next(front);
        end else begin
          rear_next = ring_prev(rear);
        end
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= value;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front <= '0;
      rear  <= '0;
      empty <= 1'b1;
      mode  <= cde_pkg::mode_t'(cde_pkg::MODE_RESET);
    end else if (cfg_wr) begin
      // a mode write empties the deque
      mode  <= cde_pkg::mode_t'(pwdata[1:0]);
      front <= '0;
      rear  <= '0;
      empty <= 1'b1;
    end else begin
      front <= front_next;
      rear  <= rear_next;
      empty <= empty_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      pend_status <= cmd.status;
      pend_pop    <= (cmd.op == cde_pkg::OP_POP_FRONT) || (cmd.op == cde_pkg::OP_POP_REAR);
      pend_empty  <= empty_next;
      pend_full   <= full_next;
    end
    if (cmd.load_out) begin
      out_status <= pend_status;
      out_data   <= pend_pop ? rd_data : 32'd0;
      out_empty  <= pend_empty;
      out_full   <= pend_full;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {6'd0, out_full, out_empty, out_data};
  assign m_tuser  = out_status;
  assign prdata   = (paddr[2] == REG_MODE_SEL) ? {30'd0, mode} : 32'd0;

  assign stat.is_empty  = empty;
  assign stat.is_full   = full;
  assign stat.mode      = mode;
  assign stat.out_valid = out_valid;

endmodule

// ===== rtl/core/circular_deque_engine.sv =====
// Top level of the circular deque engine: controller plus datapath.
//
//  channel  | dir | handshake                 | payload
//  ---------+-----+---------------------------+------------------------------------------
//  s_*      | in  | s_tvalid / s_tready        | tuser: req_type; tdata: value
//  m_*      | out | m_tvalid / m_tready        | tuser: status; tdata: data, now_empty, now_full
//  APB      | in  | psel, penable, pwrite      | byte 0: restriction_mode (2 bits)
//
//  An item is handled in S_IDLE and then S_EXEC: the accept cycle updates the pointers
//  and starts the synchronous slot read, and S_EXEC loads the output register from the
//  read port once the output register is free; only then is a new item accepted.
//  Reset empties the deque and sets the mode to unrestricted; slot contents are not cleared.
//  While the output register is full and m_tready is low, the finished item waits in the
//  datapath and s_tready stays low until the output register frees.
module circular_deque_engine #(
  parameter int DEPTH = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] value
  input  logic [1:0]  s_tuser,   // [1:0] req_type
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [31:0] data, [32] now_empty, [33] now_full, [39:34] zero
  output logic [1:0]  m_tuser,   // [1:0] status
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cde_pkg::cmd_t     cmd;
  cde_pkg::dp_stat_t stat;

  assign pready = 1'b1;

  cde_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .req_bits (s_tuser),
    .m_tready (m_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  cde_datapath #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .stat     (stat),
    .value    (s_tdata),
    .m_tready (m_tready),
    .m_tvalid (m_tvalid),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata)
  );

endmodule

// ===== rtl/core/cde_checker.sv =====
// Port-level checker for the circular deque engine, bound to the top level.
module cde_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata,
  input logic [1:0]  m_tuser
);

  // hold a stalled result
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // refused requests return no word
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser != cde_pkg::ST_DONE) |-> (m_tdata[31:0] == 32'd0))
    else $error("refused request returned data");

  // an empty refusal leaves the deque empty, a full refusal leaves it full
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == cde_pkg::ST_EMPTY) |-> m_tdata[32] && !m_tdata[33])
    else $error("empty refusal with deque not empty");

  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == cde_pkg::ST_FULL) |-> m_tdata[33] && !m_tdata[32])
    else $error("full refusal with deque not full");

endmodule

bind circular_deque_engine cde_checker u_cde_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
